FILE: hdl/shor_period_post_processing_unit_assert.svh
// Assertion macros for the period post-processing block.
`ifndef SHOR_PERIOD_POST_PROCESSING_UNIT_ASSERT_SVH
`define SHOR_PERIOD_POST_PROCESSING_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SPPU_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sppu assertion failed");
`define SPPU_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sppu assertion failed");
`else
`define SPPU_ASSERT_IMP(label, ante, cons)
`define SPPU_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: hdl/sppu_pkg.sv
// Shared types and constants of the period post-processing block.
`default_nettype none
package sppu_pkg;
	localparam int MAX_BITS   = 16;
	localparam int TERM_DEPTH = 64;
	localparam int CNT_W      = $clog2(TERM_DEPTH + 1);
	localparam int DIV_STEPS  = 33;

	// register indexes
	localparam logic [1:0] REG_MODULUS   = 2'd0;
	localparam logic [1:0] REG_BASE      = 2'd1;
	localparam logic [1:0] REG_BIT_COUNT = 2'd2;

	// result status codes
	localparam logic [2:0] ST_SUCCESS   = 3'd0;
	localparam logic [2:0] ST_MEAS_ZERO = 3'd1;
	localparam logic [2:0] ST_DEN_LARGE = 3'd2;
	localparam logic [2:0] ST_ODD       = 3'd3;
	localparam logic [2:0] ST_TRIVIAL   = 3'd4;
	localparam logic [2:0] ST_NO_CAND   = 3'd5;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_CF_DIV, OP_CF_TERM, OP_MUL_P, OP_ADD_P, OP_MUL_Q,
		OP_ADD_Q, OP_SHIFT_PQ, OP_MUL_V, OP_DIST, OP_DIV_BASE, OP_MP_LOAD_Q,
		OP_MP_LOAD_H, OP_MUL_ACC, OP_DIV_PROD, OP_SET_ACC, OP_MUL_SQ, OP_SET_B,
		OP_G_INIT, OP_X_MUL, OP_X_SET, OP_H_SET, OP_GCD_LOAD1, OP_GCD_LOAD2,
		OP_GCD_DIV, OP_GCD_STEP, OP_GCD_SAVE1, OP_GCD_SAVE2, OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [2:0] code;
	} sppu_cmd_t;

	typedef struct packed {
		logic div_busy;
		logic v_zero;
		logic cf_end;
		logic q_gt_n;
		logic far;
		logic exp_zero;
		logic exp_bit0;
		logic loop_go;
		logic x_one;
		logic r_odd;
		logic gy_zero;
		logic trivial;
	} sppu_stat_t;
endpackage
`default_nettype wire

FILE: hdl/sppu_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module sppu_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [32:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             busy,
	output logic [32:0]      quotient,
	output logic [31:0]      remainder
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [32:0] quo_q;
	logic [31:0] dsr_q;
	logic [32:0] trial;
	logic        ge;
	logic [32:0] nxt;

	assign trial = {rem_q, quo_q[32]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign nxt   = ge ? trial - {1'b0, dsr_q} : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(sppu_pkg::DIV_STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= nxt[31:0];
			quo_q <= {quo_q[31:0], ge};
		end
	end

	assign busy      = busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

FILE: hdl/sppu_dpath.sv
// Datapath: fraction expansion, convergents, modular powers and gcd.
`default_nettype none
module sppu_dpath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire sppu_pkg::sppu_cmd_t  cmd,
	input  wire logic [31:0]          measurement,
	input  wire logic [15:0]          modulus,
	input  wire logic [15:0]          base,
	input  wire logic [4:0]           bit_count,
	output sppu_pkg::sppu_stat_t      stat,
	output logic [15:0]               factor_one,
	output logic [15:0]               factor_two,
	output logic [2:0]                status
);
	logic [5:0]  sh_q;
	logic [31:0] v_q;
	logic [32:0] num_q;
	logic [31:0] den_q;
	logic [sppu_pkg::CNT_W-1:0] cnt_q;
	logic [31:0] term_q;
	logic [15:0] p_q, pp_q, pn_q, q_q, qp_q;
	logic [48:0] qn_q;
	logic [47:0] prod_q;
	logic        far_q;
	logic [15:0] mb_q, acc_q, g_q, x_q;
	logic [16:0] exp_q, r_q;
	logic [15:0] f1_q, f2_q, gx_q, gy_q;
	logic [15:0] fo_q, ft_q;
	logic [2:0]  st_q;

	logic [4:0]  n_sat;
	logic [5:0]  sh_d;
	logic [32:0] mask_d;
	logic [31:0] mul_a;
	logic [15:0] mul_b;
	logic        mul_en;
	logic        div_start;
	logic [32:0] div_dnd;
	logic [31:0] div_dsr;
	logic        div_busy;
	logic [32:0] div_quo;
	logic [31:0] div_rem;
	logic [47:0] rhs;
	logic [47:0] diff;
	logic [16:0] hp1;

	sppu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dnd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// clamp n to 2..MAX_BITS
	always_comb begin
		if (bit_count < 5'd2) begin
			n_sat = 5'd2;
		end else if (bit_count > 5'(sppu_pkg::MAX_BITS)) begin
			n_sat = 5'(sppu_pkg::MAX_BITS);
		end else begin
			n_sat = bit_count;
		end
		sh_d   = {n_sat, 1'b0};
		mask_d = (33'd1 << sh_d) - 33'd1;
	end

	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		unique case (cmd.op)
			sppu_pkg::OP_MUL_P:   begin mul_a = term_q;       mul_b = p_q;  end
			sppu_pkg::OP_MUL_Q:   begin mul_a = term_q;       mul_b = q_q;  end
			sppu_pkg::OP_MUL_V:   begin mul_a = v_q;          mul_b = q_q;  end
			sppu_pkg::OP_MUL_ACC: begin mul_a = {16'd0, acc_q}; mul_b = mb_q; end
			sppu_pkg::OP_MUL_SQ:  begin mul_a = {16'd0, mb_q};  mul_b = mb_q; end
			sppu_pkg::OP_X_MUL:   begin mul_a = {16'd0, x_q};   mul_b = g_q;  end
			default:              mul_en = 1'b0;
		endcase
	end

	always_comb begin
		div_start = 1'b1;
		div_dnd   = '0;
		div_dsr   = '0;
		unique case (cmd.op)
			sppu_pkg::OP_CF_DIV: begin
				div_dnd = num_q;
				div_dsr = den_q;
			end
			sppu_pkg::OP_DIV_BASE: begin
				div_dnd = {17'd0, base};
				div_dsr = {16'd0, modulus};
			end
			sppu_pkg::OP_DIV_PROD: begin
				div_dnd = {1'b0, prod_q[31:0]};
				div_dsr = {16'd0, modulus};
			end
			sppu_pkg::OP_GCD_DIV: begin
				div_dnd = {17'd0, gx_q};
				div_dsr = {16'd0, gy_q};
			end
			default: div_start = 1'b0;
		endcase
	end

	assign rhs  = 48'(p_q) << sh_q;
	assign diff = (prod_q >= rhs) ? prod_q - rhs : rhs - prod_q;
	assign hp1  = {1'b0, acc_q} + 17'd1;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		unique case (cmd.op)
			sppu_pkg::OP_LOAD: begin
				sh_q  <= sh_d;
				v_q   <= measurement & mask_d[31:0];
				num_q <= mask_d + 33'd1;
				den_q <= measurement & mask_d[31:0];
				cnt_q <= '0;
				p_q   <= 16'd0;
				pp_q  <= 16'd1;
				q_q   <= 16'd1;
				qp_q  <= 16'd0;
			end
			sppu_pkg::OP_CF_TERM: begin
				term_q <= div_quo[32] ? 32'hFFFF_FFFF : div_quo[31:0];
				num_q  <= {1'b0, den_q};
				den_q  <= div_rem;
				cnt_q  <= cnt_q + 1'b1;
			end
			sppu_pkg::OP_ADD_P: pn_q <= prod_q[15:0] + pp_q;
			sppu_pkg::OP_ADD_Q: qn_q <= {1'b0, prod_q} + {33'd0, qp_q};
			sppu_pkg::OP_SHIFT_PQ: begin
				pp_q <= p_q;
				p_q  <= pn_q;
				qp_q <= q_q;
				q_q  <= qn_q[15:0];
			end
			sppu_pkg::OP_DIST: far_q <= {diff, 1'b0} >= {33'd0, q_q};
			sppu_pkg::OP_MP_LOAD_Q: begin
				mb_q  <= div_rem[15:0];
				acc_q <= (modulus == 16'd1) ? 16'd0 : 16'd1;
				exp_q <= {1'b0, q_q};
			end
			sppu_pkg::OP_MP_LOAD_H: begin
				mb_q  <= div_rem[15:0];
				acc_q <= (modulus == 16'd1) ? 16'd0 : 16'd1;
				exp_q <= {1'b0, r_q[16:1]};
			end
			sppu_pkg::OP_SET_ACC: acc_q <= div_rem[15:0];
			sppu_pkg::OP_SET_B: begin
				mb_q  <= div_rem[15:0];
				exp_q <= exp_q >> 1;
			end
			sppu_pkg::OP_G_INIT: begin
				g_q <= acc_q;
				x_q <= acc_q;
				r_q <= {1'b0, q_q};
			end
			sppu_pkg::OP_X_SET: begin
				x_q <= div_rem[15:0];
				r_q <= r_q + {1'b0, q_q};
			end
			sppu_pkg::OP_H_SET: begin
				f1_q <= (acc_q == 16'd0) ? modulus - 16'd1 : acc_q - 16'd1;
				f2_q <= (hp1 == {1'b0, modulus}) ? 16'd0 : hp1[15:0];
			end
			sppu_pkg::OP_GCD_LOAD1: begin
				gx_q <= f1_q;
				gy_q <= modulus;
			end
			sppu_pkg::OP_GCD_LOAD2: begin
				gx_q <= f2_q;
				gy_q <= modulus;
			end
			sppu_pkg::OP_GCD_STEP: begin
				gx_q <= gy_q;
				gy_q <= div_rem[15:0];
			end
			sppu_pkg::OP_GCD_SAVE1: f1_q <= gx_q;
			sppu_pkg::OP_GCD_SAVE2: f2_q <= gx_q;
			sppu_pkg::OP_EMIT: begin
				st_q <= cmd.code;
				fo_q <= (cmd.code == sppu_pkg::ST_SUCCESS) ? f1_q : 16'd0;
				ft_q <= (cmd.code == sppu_pkg::ST_SUCCESS) ? f2_q : 16'd0;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.div_busy = div_busy;
		stat.v_zero   = v_q == 32'd0;
		stat.cf_end   = (den_q == 32'd0) || (cnt_q == sppu_pkg::CNT_W'(sppu_pkg::TERM_DEPTH));
		stat.q_gt_n   = qn_q > {33'd0, modulus};
		stat.far      = far_q;
		stat.exp_zero = exp_q == 17'd0;
		stat.exp_bit0 = exp_q[0];
		stat.loop_go  = (r_q < {1'b0, modulus}) && (x_q != 16'd1);
		stat.x_one    = x_q == 16'd1;
		stat.r_odd    = r_q[0];
		stat.gy_zero  = gy_q == 16'd0;
		stat.trivial  = (f1_q == 16'd1) || (f2_q == 16'd1);
	end

	assign factor_one = fo_q;
	assign factor_two = ft_q;
	assign status     = st_q;
endmodule
`default_nettype wire

FILE: hdl/sppu_ctrl.sv
// Controller state machine: sequences the datapath and drives the handshakes.
`default_nettype none
module sppu_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 meas_valid,
	output logic                      meas_stall,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	input  wire sppu_pkg::sppu_stat_t stat,
	output sppu_pkg::sppu_cmd_t       cmd
);
	typedef enum logic [27:0] {
		S_IDLE      = 28'h0000001,
		S_CHK0      = 28'h0000002,
		S_CF_TEST   = 28'h0000004,
		S_CF_WAIT   = 28'h0000008,
		S_MUL_P     = 28'h0000010,
		S_ADD_P     = 28'h0000020,
		S_MUL_Q     = 28'h0000040,
		S_ADD_Q     = 28'h0000080,
		S_CHK_Q     = 28'h0000100,
		S_MUL_V     = 28'h0000200,
		S_DIST      = 28'h0000400,
		S_CHK_DIST  = 28'h0000800,
		S_BASE_WAIT = 28'h0001000,
		S_MP_TEST   = 28'h0002000,
		S_ACC_DIV   = 28'h0004000,
		S_ACC_WAIT  = 28'h0008000,
		S_SQ_MUL    = 28'h0010000,
		S_SQ_DIV    = 28'h0020000,
		S_SQ_WAIT   = 28'h0040000,
		S_LOOP_TEST = 28'h0080000,
		S_X_DIV     = 28'h0100000,
		S_X_WAIT    = 28'h0200000,
		S_G1_LOAD   = 28'h0400000,
		S_G_TEST    = 28'h0800000,
		S_G_WAIT    = 28'h1000000,
		S_G2_LOAD   = 28'h2000000,
		S_CHK_TRIV  = 28'h4000000,
		S_OUT       = 28'h8000000
	} state_t;

	state_t state_q, state_d;
	logic   half_q, half_d;
	logic   second_q, second_d;

	always_comb begin
		state_d  = state_q;
		half_d   = half_q;
		second_d = second_q;
		cmd.op   = sppu_pkg::OP_NOP;
		cmd.code = sppu_pkg::ST_SUCCESS;
		unique case (state_q)
			S_IDLE: if (meas_valid) begin
				cmd.op  = sppu_pkg::OP_LOAD;
				state_d = S_CHK0;
			end
			S_CHK0: if (stat.v_zero) begin
				cmd.op   = sppu_pkg::OP_EMIT;
				cmd.code = sppu_pkg::ST_MEAS_ZERO;
				state_d  = S_OUT;
			end else begin
				state_d = S_CF_TEST;
			end
			S_CF_TEST: if (stat.cf_end) begin
				cmd.op   = sppu_pkg::OP_EMIT;
				cmd.code = sppu_pkg::ST_NO_CAND;
				state_d  = S_OUT;
			end else begin
				cmd.op  = sppu_pkg::OP_CF_DIV;
				state_d = S_CF_WAIT;
			end
			S_CF_WAIT: if (!stat.div_busy) begin
				cmd.op  = sppu_pkg::OP_CF_TERM;
				state_d = S_MUL_P;
			end
			S_MUL_P: begin
				cmd.op  = sppu_pkg::OP_MUL_P;
				state_d = S_ADD_P;
			end
			S_ADD_P: begin
				cmd.op  = sppu_pkg::OP_ADD_P;
				state_d = S_MUL_Q;
			end
			S_MUL_Q: begin
				cmd.op  = sppu_pkg::OP_MUL_Q;
				state_d = S_ADD_Q;
			end
			S_ADD_Q: begin
				cmd.op  = sppu_pkg::OP_ADD_Q;
				state_d = S_CHK_Q;
			end
			S_CHK_Q: if (stat.q_gt_n) begin
				cmd.op   = sppu_pkg::OP_EMIT;
				cmd.code = sppu_pkg::ST_DEN_LARGE;
				state_d  = S_OUT;
			end else begin
				cmd.op  = sppu_pkg::OP_SHIFT_PQ;
				state_d = S_MUL_V;
			end
			S_MUL_V: begin
				cmd.op  = sppu_pkg::OP_MUL_V;
				state_d = S_DIST;
			end
			S_DIST: begin
				cmd.op  = sppu_pkg::OP_DIST;
				state_d = S_CHK_DIST;
			end
			S_CHK_DIST: if (stat.far) begin
				state_d = S_CF_TEST;
			end else begin
				cmd.op  = sppu_pkg::OP_DIV_BASE;
				half_d  = 1'b0;
				state_d = S_BASE_WAIT;
			end
			S_BASE_WAIT: if (!stat.div_busy) begin
				cmd.op  = half_q ? sppu_pkg::OP_MP_LOAD_H : sppu_pkg::OP_MP_LOAD_Q;
				state_d = S_MP_TEST;
			end
			S_MP_TEST: if (stat.exp_zero) begin
				if (half_q) begin
					cmd.op  = sppu_pkg::OP_H_SET;
					state_d = S_G1_LOAD;
				end else begin
					cmd.op  = sppu_pkg::OP_G_INIT;
					state_d = S_LOOP_TEST;
				end
			end else if (stat.exp_bit0) begin
				cmd.op  = sppu_pkg::OP_MUL_ACC;
				state_d = S_ACC_DIV;
			end else begin
				cmd.op  = sppu_pkg::OP_MUL_SQ;
				state_d = S_SQ_DIV;
			end
			S_ACC_DIV: begin
				cmd.op  = sppu_pkg::OP_DIV_PROD;
				state_d = S_ACC_WAIT;
			end
			S_ACC_WAIT: if (!stat.div_busy) begin
				cmd.op  = sppu_pkg::OP_SET_ACC;
				state_d = S_SQ_MUL;
			end
			S_SQ_MUL: begin
				cmd.op  = sppu_pkg::OP_MUL_SQ;
				state_d = S_SQ_DIV;
			end
			S_SQ_DIV: begin
				cmd.op  = sppu_pkg::OP_DIV_PROD;
				state_d = S_SQ_WAIT;
			end
			S_SQ_WAIT: if (!stat.div_busy) begin
				cmd.op  = sppu_pkg::OP_SET_B;
				state_d = S_MP_TEST;
			end
			S_LOOP_TEST: priority if (stat.loop_go) begin
				cmd.op  = sppu_pkg::OP_X_MUL;
				state_d = S_X_DIV;
			end else if (!stat.x_one) begin
				state_d = S_CF_TEST;
			end else if (stat.r_odd) begin
				cmd.op   = sppu_pkg::OP_EMIT;
				cmd.code = sppu_pkg::ST_ODD;
				state_d  = S_OUT;
			end else begin
				cmd.op  = sppu_pkg::OP_DIV_BASE;
				half_d  = 1'b1;
				state_d = S_BASE_WAIT;
			end
			S_X_DIV: begin
				cmd.op  = sppu_pkg::OP_DIV_PROD;
				state_d = S_X_WAIT;
			end
			S_X_WAIT: if (!stat.div_busy) begin
				cmd.op  = sppu_pkg::OP_X_SET;
				state_d = S_LOOP_TEST;
			end
			S_G1_LOAD: begin
				cmd.op   = sppu_pkg::OP_GCD_LOAD1;
				second_d = 1'b0;
				state_d  = S_G_TEST;
			end
			S_G_TEST: if (stat.gy_zero) begin
				cmd.op  = second_q ? sppu_pkg::OP_GCD_SAVE2 : sppu_pkg::OP_GCD_SAVE1;
				state_d = second_q ? S_CHK_TRIV : S_G2_LOAD;
			end else begin
				cmd.op  = sppu_pkg::OP_GCD_DIV;
				state_d = S_G_WAIT;
			end
			S_G_WAIT: if (!stat.div_busy) begin
				cmd.op  = sppu_pkg::OP_GCD_STEP;
				state_d = S_G_TEST;
			end
			S_G2_LOAD: begin
				cmd.op   = sppu_pkg::OP_GCD_LOAD2;
				second_d = 1'b1;
				state_d  = S_G_TEST;
			end
			S_CHK_TRIV: begin
				cmd.op   = sppu_pkg::OP_EMIT;
				cmd.code = stat.trivial ? sppu_pkg::ST_TRIVIAL : sppu_pkg::ST_SUCCESS;
				state_d  = S_OUT;
			end
			S_OUT: if (!result_stall) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			half_q   <= 1'b0;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			half_q   <= half_d;
			second_q <= second_d;
		end
	end

	assign meas_stall   = state_q != S_IDLE;
	assign result_valid = state_q == S_OUT;
endmodule
`default_nettype wire

FILE: hdl/shor_period_post_processing_unit.sv
// Top level of the period post-processing block: config registers and wiring.
//
// Usage:
//  - Measurement channel (meas_valid / meas_stall): one 32-bit word per item;
//    only the low 2n bits are used, n = bit_count clamped to 2..16.
//  - Result channel (result_valid / result_stall): one word per measurement
//    carrying factor_one, factor_two and a 3-bit status code.
//  - Config channel (cfg_valid / cfg_ready): index 0 modulus, 1 base,
//    2 bit_count; cfg_ready is always high. Write only while idle.
//  - One item at a time: meas_stall is high from acceptance until the
//    result word has been taken.
//  - Latency is data dependent. Every division and every modular reduction
//    goes through one shared restoring divider. Each fraction term takes one
//    division, a candidate adds one modular power (two reductions per set
//    exponent bit, one per clear bit) plus a period search of up to N/q
//    modular multiplies; each of the two gcds adds up to ~24 divider passes.
//  - Reset clears the controller to idle and loads modulus 15, base 7,
//    bit_count 4. No result is pending after reset.
//  - While result_stall is high the result word holds and no new
//    measurement is taken.
`default_nettype none
`include "shor_period_post_processing_unit_assert.svh"
module shor_period_post_processing_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        meas_valid,
	output logic             meas_stall,
	input  wire logic [31:0] measurement,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [15:0]      factor_one,
	output logic [15:0]      factor_two,
	output logic [2:0]       status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic [15:0] modulus_q;
	logic [15:0] base_q;
	logic [4:0]  bit_count_q;
	sppu_pkg::sppu_cmd_t  cmd;
	sppu_pkg::sppu_stat_t stat;

	assign cfg_ready = 1'b1;

	// config registers; an index past the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q   <= 16'd15;
			base_q      <= 16'd7;
			bit_count_q <= 5'd4;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				sppu_pkg::REG_MODULUS:   modulus_q   <= cfg_data[15:0];
				sppu_pkg::REG_BASE:      base_q      <= cfg_data[15:0];
				sppu_pkg::REG_BIT_COUNT: bit_count_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	sppu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.meas_valid   (meas_valid),
		.meas_stall   (meas_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	sppu_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.measurement (measurement),
		.modulus     (modulus_q),
		.base        (base_q),
		.bit_count   (bit_count_q),
		.stat        (stat),
		.factor_one  (factor_one),
		.factor_two  (factor_two),
		.status      (status)
	);

	// a pending result keeps the input side closed
	`SPPU_ASSERT_IMP(a_busy_while_out, result_valid, meas_stall)
	// an accepted word closes the input side on the next cycle
	`SPPU_ASSERT_NXT(a_busy_after_accept, meas_valid && !meas_stall, meas_stall)
	// failures never carry factors
	`SPPU_ASSERT_IMP(a_fail_zero, result_valid && status != sppu_pkg::ST_SUCCESS, factor_one == 16'd0 && factor_two == 16'd0)
	// divider is never left running when the block goes idle
	`SPPU_ASSERT_IMP(a_div_idle, !meas_stall, !stat.div_busy)
endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the period post-processing block.
`timescale 1ns / 100ps
`default_nettype none
module tb;
	// one result word as predicted
	typedef struct packed {
		logic [15:0] f_one;
		logic [15:0] f_two;
		logic [2:0]  st;
	} factor_word_t;

	localparam int WATCHDOG_LIMIT = 4_000_000;
	localparam int HOLD_CYCLES    = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        meas_valid = 1'b0;
	logic        meas_stall;
	logic [31:0] measurement = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] factor_one;
	logic [15:0] factor_two;
	logic [2:0]  status;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = sppu_pkg::REG_MODULUS;
	logic [31:0] cfg_data = '0;

	shor_period_post_processing_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.meas_valid   (meas_valid),
		.meas_stall   (meas_stall),
		.measurement  (measurement),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.factor_one   (factor_one),
		.factor_two   (factor_two),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow copy of the config registers, updated on every accepted write.
	logic [15:0] n_mod = 16'd15;
	logic [15:0] a_base = 16'd7;
	logic [4:0]  n_bits = 5'd4;

	logic [31:0]  meas_q[$];    // measurements waiting to be offered
	factor_word_t factor_q[$];  // predicted result words, oldest first
	int unsigned  n_queued = 0;
	int unsigned  n_taken = 0;
	int unsigned  n_errors = 0;
	int unsigned  tx_idle_pct = 0;
	int unsigned  rx_stall_pct = 0;
	int unsigned  hold_req = 0;
	int unsigned  hold_ack = 0;
	int unsigned  hold_cnt = 0;
	int unsigned  quiet_cycles = 0;

	function automatic longint unsigned pow_mod(longint unsigned b, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		if (m == 0)
			return 0;
		acc = 1 % m;
		b = b % m;
		while (e != 0) begin
			if (e[0])
				acc = (acc * b) % m;
			b = (b * b) % m;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	// effective n: bit_count clamped to 2..MAX_BITS
	function automatic int eff_bits();
		if (n_bits < 2)
			return 2;
		if (n_bits > sppu_pkg::MAX_BITS)
			return sppu_pkg::MAX_BITS;
		return n_bits;
	endfunction

	function automatic factor_word_t mk_word(longint unsigned f1, longint unsigned f2,
			logic [2:0] st);
		factor_word_t w;
		w.f_one = f1[15:0];
		w.f_two = f2[15:0];
		w.st    = st;
		return w;
	endfunction

	// Continued-fraction expansion of v/2^(2n), then walk the convergents.
	function automatic factor_word_t factor_from_meas(logic [31:0] meas);
		longint unsigned full, v, num, den, t, rem, nm;
		longint unsigned pp, qp, p, q, pn, qn, lhs, rhs, diff, k, r, h, f1, f2;
		logic [31:0] cf[sppu_pkg::TERM_DEPTH];
		int cnt;
		full = 64'd1 << (2 * eff_bits());
		v = meas & (full - 1);
		nm = n_mod;
		cnt = 0;
		pp = 1; qp = 0; p = 0; q = 1;
		if (v == 0)
			return mk_word(0, 0, sppu_pkg::ST_MEAS_ZERO);
		num = full;
		den = v;
		while (den != 0) begin
			t = num / den;
			rem = num % den;
			if (cnt < sppu_pkg::TERM_DEPTH) begin
				cf[cnt] = (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
				cnt++;
			end
			num = den;
			den = rem;
		end
		for (int i = 0; i < cnt; i++) begin
			pn = cf[i] * p + pp;
			qn = cf[i] * q + qp;
			pp = p; qp = q; p = pn; q = qn;
			if (q > nm)
				return mk_word(0, 0, sppu_pkg::ST_DEN_LARGE);
			lhs = v * q;
			rhs = p * full;
			diff = (lhs >= rhs) ? lhs - rhs : rhs - lhs;
			if (2 * diff >= q)
				continue;
			k = 1;
			while (q * k < nm && pow_mod(a_base, q * k, nm) != 1)
				k++;
			r = q * k;
			if (pow_mod(a_base, r, nm) != 1)
				continue;
			if (r[0])
				return mk_word(0, 0, sppu_pkg::ST_ODD);
			h = pow_mod(a_base, r / 2, nm);
			f2 = gcd64((h + 1) % nm, nm);
			f1 = gcd64((h == 0) ? nm - 1 : h - 1, nm);
			if (f1 == 1 || f2 == 1)
				return mk_word(0, 0, sppu_pkg::ST_TRIVIAL);
			return mk_word(f1, f2, sppu_pkg::ST_SUCCESS);
		end
		return mk_word(0, 0, sppu_pkg::ST_NO_CAND);
	endfunction

	// order of the base mod N, zero if it has none below N
	function automatic int unsigned base_order();
		longint unsigned x;
		if (n_mod < 2)
			return 0;
		x = a_base % n_mod;
		for (int unsigned r = 1; r < n_mod; r++) begin
			if (x == 1)
				return r;
			x = (x * a_base) % n_mod;
		end
		return 0;
	endfunction

	task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
		$display("mismatch: %s got %0d expected %0d (result word %0d)", what, got, want,
			n_taken);
		n_errors++;
	endtask

	// Measurement driver. A stalled word holds; otherwise the next word is
	// offered unless this cycle is picked as a sender gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (meas_valid && !meas_stall)
				factor_q.push_back(factor_from_meas(measurement));
			if (!(meas_valid && meas_stall)) begin
				if (meas_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					measurement <= meas_q.pop_front();
					meas_valid  <= 1'b1;
				end else begin
					meas_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here on request from the sequence.
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_cnt <= HOLD_CYCLES;
		end else if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
		end
	end

	// Result monitor: compare each taken word against the oldest prediction.
	always @(posedge clk) begin
		factor_word_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (factor_q.size() == 0) begin
					report_mismatch("unexpected word, status", status, 0);
				end else begin
					want = factor_q.pop_front();
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (factor_one !== want.f_one)
						report_mismatch("factor_one", factor_one, want.f_one);
					if (factor_two !== want.f_two)
						report_mismatch("factor_two", factor_two, want.f_two);
				end
				n_taken++;
			end
			result_stall <= (hold_cnt != 0) || ($urandom_range(0, 99) < rx_stall_pct);
		end
	end

	// Watchdog: any accepted word on any channel resets the count.
	always @(posedge clk) begin
		if ((meas_valid && !meas_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Wait at a falling edge until every queued word has come back.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (n_taken != n_queued || meas_valid);
	endtask

	// Register write; only called with the block idle.
	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			sppu_pkg::REG_MODULUS:   n_mod  = data[15:0];
			sppu_pkg::REG_BASE:      a_base = data[15:0];
			sppu_pkg::REG_BIT_COUNT: n_bits = data[4:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Upper config bits are junk on purpose: the block keeps only the low ones.
	task automatic set_config(int unsigned m, int unsigned a, int unsigned nb);
		wait_drained();
		write_reg(sppu_pkg::REG_MODULUS, {$urandom_range(0, 65535), m[15:0]});
		write_reg(sppu_pkg::REG_BASE, {$urandom_range(0, 65535), a[15:0]});
		write_reg(sppu_pkg::REG_BIT_COUNT, {$urandom, nb[4:0]} & 32'hFFFF_FFFF);
	endtask

	task automatic queue_meas(logic [31:0] m);
		meas_q.push_back(m);
		n_queued++;
	endtask

	// Mostly measurements near j/r of the true order, with junk above
	// bit 2n-1; some words fully random.
	task automatic queue_random(int unsigned cnt);
		longint unsigned full, v;
		int unsigned r, j;
		full = 64'd1 << (2 * eff_bits());
		r = base_order();
		for (int unsigned i = 0; i < cnt; i++) begin
			if (r == 0 || $urandom_range(0, 99) < 30) begin
				queue_meas($urandom);
			end else begin
				j = $urandom_range(0, r - 1);
				v = (j * full + r / 2) / r;
				if ($urandom_range(0, 3) == 0)
					v = v + $urandom_range(0, 4) - 2;
				v = (v & (full - 1)) | ((longint'($urandom) << (2 * eff_bits())) &
					64'hFFFF_FFFF & ~(full - 1));
				queue_meas(v[31:0]);
			end
		end
	endtask

	task automatic set_idle(int unsigned tx, int unsigned rx);
		tx_idle_pct  = tx;
		rx_stall_pct = rx;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: reset config N=15, a=7, n=4 (256 steps).
		queue_meas(32'd0);          // measured zero
		queue_meas(32'hFFFF_FF00);  // only ignored high bits set -> zero
		queue_meas(32'd128);        // 1/2 -> period 4, factors 3 and 5
		queue_meas(32'd64);
		queue_meas(32'd192);
		queue_meas(32'd1);          // denominator runs past N
		queue_meas(32'd255);
		queue_meas(32'd85);
		// a = -1 mod 15: period 2 gives trivial factors
		set_config(15, 14, 4);
		queue_meas(32'd128);
		// order 3 of 4 mod 21: odd period
		set_config(21, 4, 5);
		queue_meas(32'd341);
		queue_meas(32'd683);
		// widest measurement, huge first term, biggest modulus
		set_config(65535, 2, 16);
		queue_meas(32'd1);
		queue_meas(32'h8000_0000);
		queue_meas(32'hFFFF_FFFF);
		set_config(65535, 65534, 16);
		queue_meas(32'h8000_0000);
		// degenerate moduli
		set_config(0, 7, 4);
		queue_meas(32'd128);
		set_config(1, 2, 4);
		queue_meas(32'd128);
		set_config(2, 3, 4);
		queue_meas(32'd128);
		// bit_count out of range on both sides
		set_config(3, 2, 0);
		queue_meas(32'hFFFF_FFF8);
		queue_meas(32'd8);
		set_config(15, 2, 31);
		queue_meas(32'h4000_0000);
		set_config(15, 7, 1);
		queue_meas(32'd8);

		// Random, one idle mode per phase.
		set_config(15, 7, 4);
		set_idle(0, 0);
		queue_random(20);
		set_config(21, 2, 5);
		set_idle(87, 0);
		queue_random(8);
		// sender stops until every result is back, then goes on
		wait_drained();
		queue_random(8);
		set_config(35, 3, 6);
		set_idle(0, 87);
		queue_random(20);
		set_config(143, 65534, 8);
		set_idle(20, 20);
		queue_random(8);
		set_config(91, 5, 7);
		queue_random(8);
		// receiver holds off while the sender keeps offering words
		set_idle(0, 0);
		hold_req++;
		queue_random(8);

		wait_drained();
		repeat (100) @(negedge clk);
		if (n_errors == 0 && factor_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire
